// ===== rtl/pfla_pkg.sv =====
// shared constants and types of the page free list allocator
`default_nettype none

package pfla_pkg;

    // page store size, fixed by the widths of the item fields
    localparam int MAX_PAGES = 1024;
    localparam int PAGE_W    = $clog2(MAX_PAGES);
    localparam int LINK_W    = PAGE_W + 1;

    // item field widths
    localparam int CMD_W   = 3;
    localparam int PNUM_W  = 12;
    localparam int STAT_W  = 3;
    localparam int RPAGE_W = 10;
    localparam int CNT_W   = 11;

    // link word: next free page, list end or used mark
    typedef logic [LINK_W-1:0] link_t;
    typedef logic [PAGE_W-1:0] page_t;

    localparam link_t LINK_END  = LINK_W'(MAX_PAGES);
    localparam link_t LINK_USED = LINK_W'(MAX_PAGES + 1);

    // commands
    localparam logic [CMD_W-1:0] CMD_ALLOC   = 3'd0;
    localparam logic [CMD_W-1:0] CMD_DISPOSE = 3'd1;
    localparam logic [CMD_W-1:0] CMD_CHECK   = 3'd2;
    localparam logic [CMD_W-1:0] CMD_NEXT    = 3'd3;
    localparam logic [CMD_W-1:0] CMD_PREV    = 3'd4;

    // status codes
    localparam logic [STAT_W-1:0] STAT_OK      = 3'd0;
    localparam logic [STAT_W-1:0] STAT_CLOSED  = 3'd1;
    localparam logic [STAT_W-1:0] STAT_INVALID = 3'd2;
    localparam logic [STAT_W-1:0] STAT_FREE    = 3'd3;
    localparam logic [STAT_W-1:0] STAT_EOF     = 3'd4;
    localparam logic [STAT_W-1:0] STAT_FULL    = 3'd5;

    // configuration register byte addresses
    localparam logic [2:0] ADDR_FILE_OPEN = 3'd0;

endpackage

`default_nettype wire

// ===== rtl/pfla_ram.sv =====
// generic single write port, single read port ram with registered read
`default_nettype none

module pfla_ram #(
    parameter int WIDTH = 11,
    parameter int DEPTH = 1024
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic                     re,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/page_free_list_allocator.sv =====
// top level of the page free list allocator: control sequencer around the link table ram
// results for closed file, bad commands, invalid pages, scans with no page to walk, store full
// and append are decided on acceptance; pop, dispose and check first read the link word of
// the head or the given page; other scans read one link word per page until a used page or the end;
// one item in work at a time, the next one is taken the cycle after a result is placed
// reset clears the sequencer, output valid, free head (list end), page count and open
// flag; the link table ram is not cleared, only entries below the page count are read
`default_nettype none

module page_free_list_allocator (
    input  wire logic        clk,
    input  wire logic        rst_n,
    // input items
    input  wire logic        s_tvalid,
    output logic             s_tready,
    input  wire logic [15:0] s_tdata,   // command [2:0], page_number [14:3], zero [15]
    // result items
    output logic             m_tvalid,
    input  wire logic        m_tready,
    output logic      [23:0] m_tdata,   // status [2:0], result_page [12:3], page_count [23:13]
    // configuration
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int PAGE_W = pfla_pkg::PAGE_W;
    localparam int LINK_W = pfla_pkg::LINK_W;

    // sequencer states
    localparam logic [2:0] S_IDLE  = 3'd0;
    localparam logic [2:0] S_ALLOC = 3'd1;   // head link read in flight
    localparam logic [2:0] S_LOOK  = 3'd2;   // dispose or check link read in flight
    localparam logic [2:0] S_SCAN  = 3'd3;   // walking link words for a used page
    localparam logic [2:0] S_OUT   = 3'd4;   // result held until the output register frees

    logic [2:0]                        state_reg, state_next;
    logic                              open_reg;
    pfla_pkg::link_t                   head_reg, head_next;
    logic [pfla_pkg::CNT_W-1:0]        count_reg, count_next;
    logic [pfla_pkg::CMD_W-1:0]        cmd_reg, cmd_next;
    pfla_pkg::page_t                   page_reg, page_next;   // lookup page or scan pointer
    logic                              up_reg, up_next;       // scan direction
    logic [pfla_pkg::STAT_W-1:0]       res_status_reg, res_status_next;
    logic [pfla_pkg::RPAGE_W-1:0]      res_page_reg, res_page_next;
    logic                              m_valid_reg, m_valid_next;
    logic [pfla_pkg::STAT_W-1:0]       m_status_reg, m_status_next;
    logic [pfla_pkg::RPAGE_W-1:0]      m_page_reg, m_page_next;
    logic [pfla_pkg::CNT_W-1:0]        m_count_reg, m_count_next;

    // link table ram port
    logic                              ram_we, ram_re;
    pfla_pkg::page_t                   ram_waddr, ram_raddr;
    pfla_pkg::link_t                   ram_wdata, ram_rdata;

    // input item fields
    logic [pfla_pkg::CMD_W-1:0]        in_cmd;
    logic [pfla_pkg::PNUM_W-1:0]       in_page;
    logic                              in_valid_pg;
    logic [pfla_pkg::CNT_W-1:0]        in_inc, in_dec;

    // finishing an item
    logic                              fin;
    logic [pfla_pkg::STAT_W-1:0]       fin_status;
    logic [pfla_pkg::RPAGE_W-1:0]      fin_page;
    logic                              out_free;
    logic                              link_used;
    logic [pfla_pkg::CNT_W-1:0]        scan_inc;

    pfla_ram #(
        .WIDTH (LINK_W),
        .DEPTH (pfla_pkg::MAX_PAGES)
    ) u_link_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // configuration port: single register; writes belong in idle only, the block does not enforce it
    assign pready = 1'b1;
    assign prdata = (paddr == pfla_pkg::ADDR_FILE_OPEN) ? {31'b0, open_reg} : 32'b0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            open_reg <= 1'b0;
        end
        else if (psel && penable && pwrite && pready && (paddr == pfla_pkg::ADDR_FILE_OPEN))
        begin
            open_reg <= pwdata[0];
        end
    end

    assign in_cmd   = s_tdata[2:0];
    assign in_page  = s_tdata[14:3];
    // page is valid when not negative and below the page count
    assign in_valid_pg = !in_page[11] && (in_page[10:0] < count_reg);
    // minus one wraps to zero in eleven bits, which is the upward scan start
    assign in_inc   = in_page[10:0] + 11'd1;
    assign in_dec   = in_page[10:0] - 11'd1;

    assign link_used = (ram_rdata == pfla_pkg::LINK_USED);
    assign scan_inc  = {1'b0, page_reg} + 11'd1;
    assign out_free  = !m_valid_reg || m_tready;
    assign s_tready  = (state_reg == S_IDLE);

    always_comb
    begin
        state_next      = state_reg;
        head_next       = head_reg;
        count_next      = count_reg;
        cmd_next        = cmd_reg;
        page_next       = page_reg;
        up_next         = up_reg;
        res_status_next = res_status_reg;
        res_page_next   = res_page_reg;
        ram_we          = 1'b0;
        ram_waddr       = page_reg;
        ram_wdata       = pfla_pkg::LINK_USED;
        ram_re          = 1'b0;
        ram_raddr       = page_reg;
        fin             = 1'b0;
        fin_status      = pfla_pkg::STAT_INVALID;
        fin_page        = '0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (s_tvalid)
                begin
                    cmd_next = in_cmd;
                    if (!open_reg)
                    begin
                        fin        = 1'b1;
                        fin_status = pfla_pkg::STAT_CLOSED;
                    end
                    else
                    begin
                        unique case (in_cmd)
                            pfla_pkg::CMD_ALLOC:
                            begin
                                if (head_reg < pfla_pkg::LINK_END)
                                begin
                                    // pop: fetch the successor of the head
                                    ram_re     = 1'b1;
                                    ram_raddr  = head_reg[PAGE_W-1:0];
                                    state_next = S_ALLOC;
                                end
                                else if (count_reg >= pfla_pkg::LINK_END)
                                begin
                                    fin        = 1'b1;
                                    fin_status = pfla_pkg::STAT_FULL;
                                end
                                else
                                begin
                                    // empty list: append a fresh page
                                    ram_we     = 1'b1;
                                    ram_waddr  = count_reg[PAGE_W-1:0];
                                    count_next = count_reg + 11'd1;
                                    fin        = 1'b1;
                                    fin_status = pfla_pkg::STAT_OK;
                                    fin_page   = count_reg[PAGE_W-1:0];
                                end
                            end
                            pfla_pkg::CMD_DISPOSE, pfla_pkg::CMD_CHECK:
                            begin
                                if (in_valid_pg)
                                begin
                                    ram_re     = 1'b1;
                                    ram_raddr  = in_page[PAGE_W-1:0];
                                    page_next  = in_page[PAGE_W-1:0];
                                    state_next = S_LOOK;
                                end
                                else
                                begin
                                    fin = 1'b1;
                                end
                            end
                            pfla_pkg::CMD_NEXT:
                            begin
                                if ((in_page == 12'hFFF) || in_valid_pg)
                                begin
                                    if (in_inc < count_reg)
                                    begin
                                        ram_re     = 1'b1;
                                        ram_raddr  = in_inc[PAGE_W-1:0];
                                        page_next  = in_inc[PAGE_W-1:0];
                                        up_next    = 1'b1;
                                        state_next = S_SCAN;
                                    end
                                    else
                                    begin
                                        fin        = 1'b1;
                                        fin_status = pfla_pkg::STAT_EOF;
                                    end
                                end
                                else
                                begin
                                    fin = 1'b1;
                                end
                            end
                            pfla_pkg::CMD_PREV:
                            begin
                                if ((!in_page[11] && (in_page[10:0] == count_reg)) || in_valid_pg)
                                begin
                                    if (in_page[10:0] == 11'd0)
                                    begin
                                        fin        = 1'b1;
                                        fin_status = pfla_pkg::STAT_EOF;
                                    end
                                    else
                                    begin
                                        ram_re     = 1'b1;
                                        ram_raddr  = in_dec[PAGE_W-1:0];
                                        page_next  = in_dec[PAGE_W-1:0];
                                        up_next    = 1'b0;
                                        state_next = S_SCAN;
                                    end
                                end
                                else
                                begin
                                    fin = 1'b1;
                                end
                            end
                            default:
                            begin
                                fin = 1'b1;
                            end
                        endcase
                    end
                end
            end
            S_ALLOC:
            begin
                // successor becomes the head, popped page marked used
                head_next  = ram_rdata;
                ram_we     = 1'b1;
                ram_waddr  = head_reg[PAGE_W-1:0];
                fin        = 1'b1;
                fin_status = pfla_pkg::STAT_OK;
                fin_page   = head_reg[PAGE_W-1:0];
            end
            S_LOOK:
            begin
                fin = 1'b1;
                if (cmd_reg == pfla_pkg::CMD_DISPOSE)
                begin
                    if (link_used)
                    begin
                        // push onto the list head
                        ram_we     = 1'b1;
                        ram_waddr  = page_reg;
                        ram_wdata  = head_reg;
                        head_next  = {1'b0, page_reg};
                        fin_status = pfla_pkg::STAT_OK;
                    end
                    else
                    begin
                        fin_status = pfla_pkg::STAT_FREE;
                    end
                end
                else if (link_used)
                begin
                    fin_status = pfla_pkg::STAT_OK;
                    fin_page   = page_reg;
                end
            end
            S_SCAN:
            begin
                if (link_used)
                begin
                    fin        = 1'b1;
                    fin_status = pfla_pkg::STAT_OK;
                    fin_page   = page_reg;
                end
                else if (up_reg)
                begin
                    if (scan_inc < count_reg)
                    begin
                        ram_re    = 1'b1;
                        ram_raddr = scan_inc[PAGE_W-1:0];
                        page_next = scan_inc[PAGE_W-1:0];
                    end
                    else
                    begin
                        fin        = 1'b1;
                        fin_status = pfla_pkg::STAT_EOF;
                    end
                end
                else if (page_reg == '0)
                begin
                    fin        = 1'b1;
                    fin_status = pfla_pkg::STAT_EOF;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = page_reg - PAGE_W'(1);
                    page_next = page_reg - PAGE_W'(1);
                end
            end
            S_OUT:
            begin
                if (out_free)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        // a finished item goes straight to the output register, or waits in S_OUT
        if (fin)
        begin
            if (out_free)
            begin
                state_next = S_IDLE;
            end
            else
            begin
                res_status_next = fin_status;
                res_page_next   = fin_page;
                state_next      = S_OUT;
            end
        end
    end

    // output register
    always_comb
    begin
        m_valid_next  = m_valid_reg;
        m_status_next = m_status_reg;
        m_page_next   = m_page_reg;
        m_count_next  = m_count_reg;
        if (fin && out_free)
        begin
            m_valid_next  = 1'b1;
            m_status_next = fin_status;
            m_page_next   = fin_page;
            m_count_next  = count_next;
        end
        else if ((state_reg == S_OUT) && out_free)
        begin
            m_valid_next  = 1'b1;
            m_status_next = res_status_reg;
            m_page_next   = res_page_reg;
            m_count_next  = count_reg;
        end
        else if (m_tready)
        begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            head_reg    <= pfla_pkg::LINK_END;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            head_reg    <= head_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        page_reg       <= page_next;
        up_reg         <= up_next;
        res_status_reg <= res_status_next;
        res_page_reg   <= res_page_next;
        m_status_reg   <= m_status_next;
        m_page_reg     <= m_page_next;
        m_count_reg    <= m_count_next;
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {m_count_reg, m_page_reg, m_status_reg};

    // free head is a page index or the list end
    a_head_range: assert property (@(posedge clk) disable iff (!rst_n)
        head_reg <= pfla_pkg::LINK_END)
        else $error("free head out of range");

    // page count never passes the store size
    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= pfla_pkg::LINK_END)
        else $error("page count out of range");

    // a held result only exists while the output register is occupied
    a_out_held: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_OUT) |-> m_valid_reg)
        else $error("result held with output register empty");

    // scans never write the link table
    a_scan_no_write: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_SCAN) |-> !ram_we)
        else $error("link write during scan");

    // the page count only grows, by one per append
    a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg != $past(count_reg)) |-> (count_reg == $past(count_reg) + 11'd1))
        else $error("page count changed by other than one");

endmodule

`default_nettype wire

// ===== tb/tb_page_free_list_allocator.sv =====
// testbench for the page free list allocator: directed and random commands checked against a predictor
`timescale 1ns / 100ps

module tb_page_free_list_allocator;

    // command codes the block does not define, answered as invalid while the file is open
    localparam logic [pfla_pkg::CMD_W-1:0] CMD_RSVD5 = 3'd5;
    localparam logic [pfla_pkg::CMD_W-1:0] CMD_RSVD7 = 3'd7;

    // how many mismatch lines get printed; later ones are only counted
    localparam int REPORT_LINES = 40;

    // one result item, with the fields the block packs into m_tdata
    typedef struct packed {
        logic [pfla_pkg::STAT_W-1:0] status;
        pfla_pkg::page_t             page;
        logic [pfla_pkg::CNT_W-1:0]  count;
    } page_reply_t;

    logic        clk      = 1'b0;
    logic        rst_n    = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [15:0] s_tdata  = '0;     // command [2:0], page_number [14:3], zero [15]
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [23:0] m_tdata;           // status [2:0], result_page [12:3], page_count [23:13]
    logic        psel     = 1'b0;
    logic        penable  = 1'b0;
    logic        pwrite   = 1'b0;
    logic [2:0]  paddr    = '0;
    logic [31:0] pwdata   = '0;
    logic [31:0] prdata;
    logic        pready;

    // shadow of the allocator: link words, free list head, page count, open flag
    pfla_pkg::link_t link_mem [pfla_pkg::MAX_PAGES];
    pfla_pkg::link_t head_model  = pfla_pkg::LINK_END;
    int              count_model = 0;
    logic            open_model  = 1'b0;

    page_reply_t expected_replies [$];
    int          mismatch_count = 0;
    bit          no_idle = 1'b0;     // set for the last part of the run
    int          stall_left = 0;

    page_free_list_allocator u_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic report_mismatch(input string what);
        if (mismatch_count < REPORT_LINES)
            $display("mismatch at %0t ns: %s", $time, what);
        mismatch_count++;
    endtask

    // works out the reply to one accepted command and updates the shadow state
    function automatic page_reply_t predict_page_op(input logic [pfla_pkg::CMD_W-1:0] cmd,
                                                    input logic [pfla_pkg::PNUM_W-1:0] pnum);
        page_reply_t r;
        int          p;
        int          i;
        p        = $signed(pnum);
        r.status = pfla_pkg::STAT_INVALID;
        r.page   = '0;
        if (!open_model)
            r.status = pfla_pkg::STAT_CLOSED;
        else
        begin
            case (cmd)
                pfla_pkg::CMD_ALLOC:
                begin
                    if (head_model < pfla_pkg::MAX_PAGES)
                    begin
                        // pop the head of the free list
                        r.page             = head_model[pfla_pkg::PAGE_W-1:0];
                        head_model         = link_mem[r.page];
                        link_mem[r.page]   = pfla_pkg::LINK_USED;
                        r.status           = pfla_pkg::STAT_OK;
                    end
                    else if (count_model >= pfla_pkg::MAX_PAGES)
                        r.status = pfla_pkg::STAT_FULL;
                    else
                    begin
                        // empty list: grow the file by one page
                        r.page                = pfla_pkg::PAGE_W'(count_model);
                        link_mem[count_model] = pfla_pkg::LINK_USED;
                        count_model++;
                        r.status              = pfla_pkg::STAT_OK;
                    end
                end
                pfla_pkg::CMD_DISPOSE:
                begin
                    if (p >= 0 && p < count_model)
                    begin
                        if (link_mem[p] != pfla_pkg::LINK_USED)
                            r.status = pfla_pkg::STAT_FREE;
                        else
                        begin
                            link_mem[p] = head_model;
                            head_model  = pfla_pkg::link_t'(p);
                            r.status    = pfla_pkg::STAT_OK;
                        end
                    end
                end
                pfla_pkg::CMD_CHECK:
                begin
                    if (p >= 0 && p < count_model && link_mem[p] == pfla_pkg::LINK_USED)
                    begin
                        r.page   = pfla_pkg::PAGE_W'(p);
                        r.status = pfla_pkg::STAT_OK;
                    end
                end
                pfla_pkg::CMD_NEXT:
                begin
                    if (p == -1 || (p >= 0 && p < count_model))
                    begin
                        r.status = pfla_pkg::STAT_EOF;
                        for (i = p + 1; i < count_model && r.status != pfla_pkg::STAT_OK; i++)
                            if (link_mem[i] == pfla_pkg::LINK_USED)
                            begin
                                r.page   = pfla_pkg::PAGE_W'(i);
                                r.status = pfla_pkg::STAT_OK;
                            end
                    end
                end
                pfla_pkg::CMD_PREV:
                begin
                    if (p == count_model || (p >= 0 && p < count_model))
                    begin
                        r.status = pfla_pkg::STAT_EOF;
                        for (i = p - 1; i >= 0 && r.status != pfla_pkg::STAT_OK; i--)
                            if (link_mem[i] == pfla_pkg::LINK_USED)
                            begin
                                r.page   = pfla_pkg::PAGE_W'(i);
                                r.status = pfla_pkg::STAT_OK;
                            end
                    end
                end
                default: ;
            endcase
        end
        if (r.status != pfla_pkg::STAT_OK)
            r.page = '0;
        r.count = pfla_pkg::CNT_W'(count_model);
        return r;
    endfunction

    // offers one item and records its expected reply once it is taken
    task automatic send_item(input logic [pfla_pkg::CMD_W-1:0] cmd, input int page);
        logic [pfla_pkg::PNUM_W-1:0] pnum;
        int                          gap;
        pnum = pfla_pkg::PNUM_W'(page);
        if (!no_idle && $urandom_range(0, 3) == 0)
        begin
            gap      = $urandom_range(1, 4);
            s_tvalid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= {1'b0, pnum, cmd};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        expected_replies.push_back(predict_page_op(cmd, pnum));
    endtask

    // drops valid after the last item of a stretch
    task automatic release_input();
        s_tvalid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic wait_for_results();
        while (expected_replies.size() != 0)
            @(posedge clk);
    endtask

    // apb write followed straight away by a read back of the same register
    task automatic write_register(input logic [2:0] addr, input logic [31:0] value);
        logic [31:0] want;
        want    = (addr == pfla_pkg::ADDR_FILE_OPEN) ? {31'b0, value[0]} : '0;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (addr == pfla_pkg::ADDR_FILE_OPEN)
            open_model = value[0];
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        if (prdata !== want)
            report_mismatch($sformatf("register %0d reads %h, wrote %h", addr, prdata, want));
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // mostly pages the command can act on, sometimes the scan edges or any 12-bit value
    function automatic int pick_page();
        case ($urandom_range(0, 9))
            0:       return $urandom_range(0, 4095);
            1:       return -1;
            2:       return count_model;
            default: return (count_model == 0) ? 0 : $urandom_range(0, count_model - 1);
        endcase
    endfunction

    // result side: m_tready dropped in random stall bursts
    always @(posedge clk)
    begin
        if (stall_left > 0)
        begin
            stall_left <= stall_left - 1;
            m_tready   <= 1'b0;
        end
        else if (!no_idle && $urandom_range(0, 5) == 0)
        begin
            stall_left <= $urandom_range(0, 3);
            m_tready   <= 1'b0;
        end
        else
            m_tready <= 1'b1;
    end

    // result checker: every taken result against the oldest expectation
    always @(posedge clk)
    begin : check_replies
        page_reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_replies.size() == 0)
                report_mismatch($sformatf("result %h with nothing expected", m_tdata));
            else
            begin
                want = expected_replies.pop_front();
                if (m_tdata[2:0] !== want.status)
                    report_mismatch($sformatf("status %0d, expected %0d",
                                              m_tdata[2:0], want.status));
                if (m_tdata[12:3] !== want.page)
                    report_mismatch($sformatf("result_page %0d, expected %0d",
                                              m_tdata[12:3], want.page));
                if (m_tdata[23:13] !== want.count)
                    report_mismatch($sformatf("page_count %0d, expected %0d",
                                              m_tdata[23:13], want.count));
            end
        end
    end

    // every command, including the undefined codes, with the file closed
    task automatic test_closed_file();
        logic [pfla_pkg::CMD_W-1:0] cmd;
        write_register(pfla_pkg::ADDR_FILE_OPEN, 32'd0);
        for (int c = pfla_pkg::CMD_ALLOC; c <= CMD_RSVD7; c++)
        begin
            cmd = pfla_pkg::CMD_W'(c);
            send_item(cmd, $urandom_range(0, 4095));
        end
        release_input();
        wait_for_results();
    endtask

    // small hand-built file: append, pop, double dispose, free check, scan edges, bad pages
    task automatic test_basic_commands();
        write_register(pfla_pkg::ADDR_FILE_OPEN, 32'd1);
        send_item(pfla_pkg::CMD_ALLOC, 0);
        send_item(pfla_pkg::CMD_ALLOC, 0);
        send_item(pfla_pkg::CMD_ALLOC, 0);
        send_item(pfla_pkg::CMD_CHECK, 1);
        send_item(pfla_pkg::CMD_DISPOSE, 1);
        send_item(pfla_pkg::CMD_DISPOSE, 1);          // already free
        send_item(pfla_pkg::CMD_CHECK, 1);            // free page reads as invalid
        send_item(pfla_pkg::CMD_NEXT, -1);
        send_item(pfla_pkg::CMD_NEXT, 0);
        send_item(pfla_pkg::CMD_NEXT, 2);             // nothing above
        send_item(pfla_pkg::CMD_PREV, 3);             // start at the page count
        send_item(pfla_pkg::CMD_PREV, 2);
        send_item(pfla_pkg::CMD_PREV, 0);             // nothing below
        send_item(pfla_pkg::CMD_DISPOSE, -1);
        send_item(pfla_pkg::CMD_CHECK, 3);
        send_item(pfla_pkg::CMD_NEXT, 3);             // count is not a legal next start
        send_item(pfla_pkg::CMD_PREV, -1);            // nor is -1 for prev
        send_item(pfla_pkg::CMD_DISPOSE, 2047);
        send_item(pfla_pkg::CMD_CHECK, -2048);
        send_item(CMD_RSVD5, 0);
        send_item(CMD_RSVD7, 4095);
        send_item(pfla_pkg::CMD_ALLOC, 4095);         // pops page 1 back
        send_item(pfla_pkg::CMD_NEXT, 0);
        release_input();
        wait_for_results();
    endtask

    task automatic test_random_traffic(input int n_items);
        int                         sel;
        logic [pfla_pkg::CMD_W-1:0] cmd;
        for (int k = 0; k < n_items; k++)
        begin
            sel = $urandom_range(0, 99);
            if (sel < 30)
                cmd = pfla_pkg::CMD_ALLOC;
            else if (sel < 55)
                cmd = pfla_pkg::CMD_DISPOSE;
            else if (sel < 68)
                cmd = pfla_pkg::CMD_CHECK;
            else if (sel < 81)
                cmd = pfla_pkg::CMD_NEXT;
            else if (sel < 95)
                cmd = pfla_pkg::CMD_PREV;
            else
                cmd = pfla_pkg::CMD_W'($urandom_range(CMD_RSVD5, CMD_RSVD7));
            // now and then hold off until the block has answered everything
            if ($urandom_range(0, 199) == 0)
            begin
                release_input();
                wait_for_results();
            end
            send_item(cmd, pick_page());
        end
        release_input();
        wait_for_results();
    endtask

    // close the file for a while, then open it again with the state untouched
    task automatic test_close_reopen();
        write_register(pfla_pkg::ADDR_FILE_OPEN, 32'd0);
        test_random_traffic(20);
        write_register(pfla_pkg::ADDR_FILE_OPEN, 32'd1);
    endtask

    // grow the file to the full store, then work at the top edge
    task automatic test_store_full();
        while (head_model < pfla_pkg::MAX_PAGES || count_model < pfla_pkg::MAX_PAGES)
            send_item(pfla_pkg::CMD_ALLOC, $urandom_range(0, 4095));
        send_item(pfla_pkg::CMD_ALLOC, 0);
        send_item(pfla_pkg::CMD_ALLOC, -1);
        send_item(pfla_pkg::CMD_NEXT, -1);
        send_item(pfla_pkg::CMD_PREV, pfla_pkg::MAX_PAGES);
        send_item(pfla_pkg::CMD_CHECK, pfla_pkg::MAX_PAGES - 1);
        send_item(pfla_pkg::CMD_DISPOSE, pfla_pkg::MAX_PAGES - 1);
        send_item(pfla_pkg::CMD_DISPOSE, 0);
        send_item(pfla_pkg::CMD_CHECK, 0);
        send_item(pfla_pkg::CMD_NEXT, -1);
        send_item(pfla_pkg::CMD_PREV, pfla_pkg::MAX_PAGES);
        send_item(pfla_pkg::CMD_DISPOSE, pfla_pkg::MAX_PAGES);
        send_item(pfla_pkg::CMD_ALLOC, 0);
        send_item(pfla_pkg::CMD_ALLOC, 0);
        send_item(pfla_pkg::CMD_ALLOC, 0);
        release_input();
        wait_for_results();
    endtask

    initial
    begin
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_closed_file();
        test_basic_commands();
        test_random_traffic(300);
        test_close_reopen();
        test_store_full();
        test_random_traffic(200);

        // last stretch at full rate on both sides
        no_idle = 1'b1;
        test_random_traffic(100);

        // extra wait before the verdict, for long scans on a full store
        repeat (1100) @(posedge clk);
        if (mismatch_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

    // watchdog for a block that hangs
    initial
    begin
        #100_000_000;
        $display("RESULT: ERROR");
        $finish;
    end

endmodule
